>>> hdl/assert_macros.svh
// Shared assertion macros. Each use expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define AST_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define AST_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rarp_pkg.sv
`default_nettype none
package rarp_pkg;

  localparam int MAX_BROKERS = 64;
  localparam int NUM_RACKS   = 16;
  localparam int MAX_RF      = 16;

  localparam int ID_W      = 16;
  localparam int RACK_IN_W = 4;
  localparam int RF_W      = 5;

  localparam int ADDR_W = (MAX_BROKERS > 1) ? $clog2(MAX_BROKERS) : 1;
  localparam int CNT_W  = $clog2(MAX_BROKERS + 1);
  localparam int RACK_W = (NUM_RACKS > 1) ? $clog2(NUM_RACKS) : 1;
  localparam int PC_W   = $clog2(MAX_RF + 1);
  localparam int PIDX_W = (MAX_RF > 1) ? $clog2(MAX_RF) : 1;

  localparam logic [RF_W-1:0] RF_RESET = RF_W'(3);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store the incoming broker entry
    logic start;       // clear rack usage and the pick count
    logic round_init;  // clear the round's best candidate, rewind the scan
    logic issue;       // read the next table entry
    logic commit;      // record the round's best candidate
    logic out_init;    // rewind the result index
    logic out_step;    // present the next result when the output is free
    logic list_clear;  // empty the broker list
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pc_full;
    logic scan_done;
    logic found;
    logic out_done;
  } sts_t;

  // Rack indices past the last rack fold onto the last rack.
  function automatic logic [RACK_W-1:0] rack_clamp(input logic [RACK_IN_W-1:0] r);
    if (32'(r) >= NUM_RACKS) begin
      return RACK_W'(NUM_RACKS - 1);
    end
    return RACK_W'(r);
  endfunction

  // The factor is limited to the size of the pick list.
  function automatic logic [PC_W-1:0] rf_sat(input logic [RF_W-1:0] rf);
    if (32'(rf) > MAX_RF) begin
      return PC_W'(MAX_RF);
    end
    return PC_W'(rf);
  endfunction

endpackage
`default_nettype wire

>>> hdl/rarp_dp.sv
`default_nettype none
module rarp_dp import rarp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 cfg_we,
  input  logic [RF_W-1:0]      cfg_data,
  input  logic [ID_W-1:0]      broker_id,
  input  logic [RACK_IN_W-1:0] rack_index,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [ID_W-1:0]      picked_id,
  output logic                 none_found,
  output logic                 last_pick
);

  logic [RF_W-1:0]        rf;
  logic [ID_W+RACK_W-1:0] mem [MAX_BROKERS];
  logic [ID_W+RACK_W-1:0] rd_word;
  logic                   rd_valid;
  logic [CNT_W-1:0]       entry_count;
  logic [CNT_W-1:0]       scan_idx;
  logic                   found;
  logic [ID_W-1:0]        best_id;
  logic [RACK_W-1:0]      best_rack;
  logic [PC_W-1:0]        best_use;
  logic [PC_W-1:0]        rack_use [NUM_RACKS];
  logic [ID_W-1:0]        picked_list [MAX_RF];
  logic [PC_W-1:0]        pc;
  logic [PC_W-1:0]        oi;

  logic [ID_W-1:0]   rd_id;
  logic [RACK_W-1:0] rd_rack;
  logic [PC_W-1:0]   rf_eff;
  logic [PC_W-1:0]   cur_use;
  logic [PC_W-1:0]   out_total;
  logic              dup;
  logic              take;
  logic              out_fire;

  assign rd_id     = rd_word[ID_W-1:0];
  assign rd_rack   = rd_word[ID_W+RACK_W-1:ID_W];
  assign rf_eff    = rf_sat(rf);
  assign cur_use   = rack_use[rd_rack];
  assign out_total = (pc == '0) ? PC_W'(1) : pc;
  assign out_fire  = cmd.out_step && (!out_valid || !out_stall);

  // An entry is skipped when its id matches any pick made so far.
  always_comb begin
    dup = 1'b0;
    for (int k = 0; k < MAX_RF; k++) begin
      if (PC_W'(k) < pc && picked_list[k] == rd_id) begin
        dup = 1'b1;
      end
    end
  end

  assign take = rd_valid && !dup && (!found || cur_use < best_use);

  assign sts.pc_full   = (pc >= rf_eff);
  assign sts.scan_done = (scan_idx == entry_count);
  assign sts.found     = found;
  assign sts.out_done  = (oi == out_total);

  // Broker table: one write port for loading, one registered read port for scans.
  always_ff @(posedge clk) begin
    if (cmd.load && entry_count < CNT_W'(MAX_BROKERS)) begin
      mem[entry_count[ADDR_W-1:0]] <= {rack_clamp(rack_index), broker_id};
    end
    if (cmd.issue) begin
      rd_word <= mem[scan_idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf          <= RF_RESET;
      entry_count <= '0;
      scan_idx    <= '0;
      rd_valid    <= 1'b0;
      found       <= 1'b0;
      pc          <= '0;
      oi          <= '0;
    end else begin
      if (cfg_we) begin
        rf <= cfg_data;
      end
      if (cmd.list_clear) begin
        entry_count <= '0;
      end else if (cmd.load && entry_count < CNT_W'(MAX_BROKERS)) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      rd_valid <= cmd.issue;
      if (cmd.round_init) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else begin
        if (cmd.issue) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        if (take) begin
          found <= 1'b1;
        end
      end
      if (cmd.start) begin
        pc <= '0;
      end else if (cmd.commit) begin
        pc <= pc + PC_W'(1);
      end
      if (cmd.out_init) begin
        oi <= '0;
      end else if (out_fire) begin
        oi <= oi + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_id   <= rd_id;
      best_rack <= rd_rack;
      best_use  <= cur_use;
    end
    if (cmd.commit) begin
      picked_list[pc[PIDX_W-1:0]] <= best_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      for (int r = 0; r < NUM_RACKS; r++) begin
        rack_use[r] <= '0;
      end
    end else if (cmd.commit) begin
      rack_use[best_rack] <= rack_use[best_rack] + PC_W'(1);
    end
  end

  // Output register: refilled only when empty or when its result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (pc == '0) begin
        picked_id  <= '0;
        none_found <= 1'b1;
        last_pick  <= 1'b1;
      end else begin
        picked_id  <= picked_list[oi[PIDX_W-1:0]];
        none_found <= 1'b0;
        last_pick  <= ((oi + PC_W'(1)) == pc);
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/rarp_ctrl.sv
`default_nettype none
module rarp_ctrl import rarp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic last_broker,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROUND  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last_broker) begin
            cmd.start  = 1'b1;
            state_next = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        if (sts.pc_full) begin
          cmd.out_init = 1'b1;
          state_next   = S_OUT;
        end else begin
          cmd.round_init = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_DRAIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.found) begin
          cmd.commit = 1'b1;
          state_next = S_ROUND;
        end else begin
          cmd.out_init = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_done) begin
          cmd.list_clear = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.out_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/rack_aware_replica_picker_top.sv
// Rack-aware greedy replica picker.
// Input channel (in_valid / in_stall): one broker per transfer, broker_id and
// rack_index, with last_broker set on the final broker of the list. A broker
// that is not last produces nothing. Up to 64 brokers are kept; later ones are
// dropped, though a dropped last broker still closes the list.
// Closing the list runs an assignment: up to R rounds (R = replication_factor,
// at most 16; a round that finds no broker ends it), each a scan of the N
// stored entries through the single read port of the broker table, one entry per cycle.
// The input stalls for the whole assignment and for the result phase.
// Output channel (out_valid / out_stall): one transfer per picked broker in
// pick order, last_pick on the final one; with no pick there is exactly one
// transfer with none_found set. Results leave one per cycle while out_stall is
// low, and a stalled result holds in the output register.
// Configuration (cfg_valid / cfg_ready): one transfer writes
// replication_factor; write it only while no assignment is pending.
// Reset (rst, synchronous) empties the list, drops any pending result and
// sets replication_factor to 3.
`default_nettype none
module rack_aware_replica_picker_top import rarp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [RF_W-1:0]      replication_factor,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ID_W-1:0]      broker_id,
  input  logic [RACK_IN_W-1:0] rack_index,
  input  logic                 last_broker,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ID_W-1:0]      picked_id,
  output logic                 none_found,
  output logic                 last_pick
);

  cmd_t cmd;
  sts_t sts;

  // The register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  rarp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .last_broker (last_broker),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  rarp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (replication_factor),
    .broker_id  (broker_id),
    .rack_index (rack_index),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .picked_id  (picked_id),
    .none_found (none_found),
    .last_pick  (last_pick)
  );

endmodule
`default_nettype wire

>>> hdl/rarp_checker.sv
`default_nettype none
`include "assert_macros.svh"
module rarp_checker import rarp_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 last_broker,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [ID_W-1:0]      picked_id,
  input logic                 none_found,
  input logic                 last_pick
);

  // A result held under stall keeps its value.
  `AST_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable({picked_id, none_found, last_pick}), "stalled result changed")

  // Closing the list starts an assignment, which blocks further brokers.
  `AST_NEXT(a_busy_after_last, clk, rst, in_valid && !in_stall && last_broker,
    in_stall, "input not stalled after last broker")

  // The empty-assignment result is a single, final, zero result.
  `AST_IMPLY(a_none_form, clk, rst, out_valid && none_found,
    last_pick && picked_id == '0, "malformed none_found result")

  // Reset leaves no result pending.
  `AST_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "result pending after reset")

endmodule

bind rack_aware_replica_picker_top rarp_checker u_rarp_checker (.*);
`default_nettype wire
